// ----- rtl/spd_pkg.sv -----
package spd_pkg;

    localparam int SAMPLE_W       = 24;
    localparam int FRAC_W         = 8;
    localparam int FRAC_ONE       = 256;
    localparam int MIX_SHIFT      = 15;
    localparam int COEF_W         = 17;
    localparam int ACC_W          = SAMPLE_W + COEF_W + 1;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int LINE_DEPTH_DEF = 65536;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_PONG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WET       = 3'd4;

    localparam logic [23:0] DELAY_RESET = 24'd256;
    localparam logic [15:0] WET_ONE     = 16'd32768;

    localparam logic signed [ACC_W-1:0] SAT_HI = 42'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_LO = -42'sd8388608;

    // Shift selection for the result scaler
    localparam logic SHIFT_FRAC = 1'b0;
    localparam logic SHIFT_GAIN = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLAMP,
        ST_SPAN,
        ST_WRAP,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_MAC,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic signed [ACC_W-1:0]    base;
        logic signed [SAMPLE_W-1:0] a;
        logic [COEF_W-1:0]          b;
    } mac_op_t;

    // Floor shift by the fraction or gain width, then clip to 24 bits
    function automatic logic signed [SAMPLE_W-1:0] shift_sat(
        input logic signed [ACC_W-1:0] v,
        input logic                    by_gain
    );
        logic signed [ACC_W-1:0] s;
        s = by_gain ? (v >>> MIX_SHIFT) : (v >>> FRAC_W);
        if (s > SAT_HI)
        begin
            s = SAT_HI;
        end
        else if (s < SAT_LO)
        begin
            s = SAT_LO;
        end
        return s[SAMPLE_W-1:0];
    endfunction

endpackage

// ----- rtl/stereo_pingpong_delay_line.sv -----
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  left_in, right_in (signed Q1.23)
// output    out        out_valid/out_stall left_out, right_out (signed Q1.23)
// config    in         cfg_we             cfg_index, cfg_data (write only)
//
// An enabled request runs from acceptance through six clamp, address and read
// states, twelve multiply-add steps, write-back, output load and the idle state
// that takes the next request. A bypassed one goes from idle straight to output load.
// After reset both delay lines are zeroed, one entry per cycle, through all LINE_DEPTH
// entries; no request is taken then, configuration writes are.
// A finished result waits in the output register while the output is stalled.
module stereo_pingpong_delay_line #(
    parameter int LINE_DEPTH = spd_pkg::LINE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [spd_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [spd_pkg::SAMPLE_W-1:0] right_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [spd_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [spd_pkg::SAMPLE_W-1:0] right_out,
    input  logic                                cfg_we,
    input  logic [spd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    // Read position: sample index plus 8 fraction bits, one spare bit for the wrap
    localparam int PW = AW + spd_pkg::FRAC_W + 1;
    localparam int DW = AW + spd_pkg::FRAC_W;
    localparam int CW = (DW > spd_pkg::CFG_DATA_W) ? DW : spd_pkg::CFG_DATA_W;

    localparam logic [PW-1:0] SPAN     = PW'(LINE_DEPTH * spd_pkg::FRAC_ONE);
    localparam logic [CW-1:0] HI_LIM   = CW'((LINE_DEPTH - 1) * spd_pkg::FRAC_ONE);
    localparam logic [CW-1:0] LO_LIM   = CW'(spd_pkg::FRAC_ONE);
    localparam logic [AW-1:0] LAST_IDX = AW'(LINE_DEPTH - 1);

    // Multiply-add schedule; each result is read once its last term has passed the product and sum registers
    localparam logic [3:0] STEP_IL0 = 4'd0;   // left interpolation, older entry
    localparam logic [3:0] STEP_IL1 = 4'd1;   // left interpolation, newer entry
    localparam logic [3:0] STEP_IR0 = 4'd2;
    localparam logic [3:0] STEP_IR1 = 4'd3;   // left tap ready
    localparam logic [3:0] STEP_FBL = 4'd4;   // left write value
    localparam logic [3:0] STEP_ML0 = 4'd5;   // right tap ready; left dry term
    localparam logic [3:0] STEP_ML1 = 4'd6;   // left write value ready; left wet term
    localparam logic [3:0] STEP_FBR = 4'd7;
    localparam logic [3:0] STEP_MR0 = 4'd8;   // left output ready
    localparam logic [3:0] STEP_MR1 = 4'd9;   // right write value ready
    localparam logic [3:0] STEP_GAP = 4'd10;
    localparam logic [3:0] STEP_END = 4'd11;  // right output ready

    localparam logic [3:0] CAP_TL = STEP_IR1;
    localparam logic [3:0] CAP_TR = STEP_ML0;
    localparam logic [3:0] CAP_WL = STEP_ML1;
    localparam logic [3:0] CAP_LO = STEP_MR0;
    localparam logic [3:0] CAP_WR = STEP_MR1;
    localparam logic [3:0] CAP_RO = STEP_END;

    // Control and state registers
    spd_pkg::state_t state_reg, state_next;
    logic [3:0]      step_reg, step_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [AW-1:0]   wi_reg, wi_next;
    logic            out_valid_reg, out_valid_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] held_l_reg, held_l_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] held_r_reg, held_r_next;

    // Configuration registers
    logic        enable_reg, enable_next;
    logic        pp_reg, pp_next;
    logic [23:0] delay_reg, delay_next;
    logic [14:0] fb_reg, fb_next;
    logic [15:0] wet_reg, wet_next;

    // Datapath registers
    logic signed [spd_pkg::SAMPLE_W-1:0] l_reg, l_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] r_reg, r_next;
    logic [DW-1:0]                       dly_reg, dly_next;
    logic [PW-1:0]                       pos_reg, pos_next;
    logic [AW-1:0]                       i0_reg, i0_next;
    logic [AW-1:0]                       i1_reg, i1_next;
    logic [spd_pkg::FRAC_W-1:0]          f_reg, f_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] s0_l_reg, s0_l_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] s0_r_reg, s0_r_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] s1_l_reg, s1_l_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] s1_r_reg, s1_r_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] tl_reg, tl_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] tr_reg, tr_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] wl_reg, wl_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] wr_reg, wr_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] res_l_reg, res_l_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] res_r_reg, res_r_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] left_out_reg, left_out_next;
    logic signed [spd_pkg::SAMPLE_W-1:0] right_out_reg, right_out_next;

    // Helpers
    logic [CW-1:0]                       d_ext;
    logic [CW-1:0]                       d_clamped;
    logic [PW-1:0]                       pos_wrapped;
    logic [15:0]                         wet_clamped;
    logic [spd_pkg::COEF_W-1:0]          dry_gain;
    logic [spd_pkg::COEF_W-1:0]          old_gain;
    logic signed [spd_pkg::SAMPLE_W-1:0] fb_tap_l;
    logic signed [spd_pkg::SAMPLE_W-1:0] fb_tap_r;
    logic                                accept;
    logic                                out_load;

    // Memory and shared unit connections
    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [AW-1:0]                       ram_raddr;
    logic [spd_pkg::SAMPLE_W-1:0]        ram_wdata_l;
    logic [spd_pkg::SAMPLE_W-1:0]        ram_wdata_r;
    logic [spd_pkg::SAMPLE_W-1:0]        ram_rdata_l;
    logic [spd_pkg::SAMPLE_W-1:0]        ram_rdata_r;
    spd_pkg::mac_op_t                    mac_op;
    logic signed [spd_pkg::ACC_W-1:0]    mac_acc;

    spd_ram #(
        .WIDTH (spd_pkg::SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_left_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata_l),
        .raddr (ram_raddr),
        .rdata (ram_rdata_l)
    );

    spd_ram #(
        .WIDTH (spd_pkg::SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_right_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata_r),
        .raddr (ram_raddr),
        .rdata (ram_rdata_r)
    );

    spd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (mac_acc)
    );

    assign in_stall  = (state_reg != spd_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    // Clamp the delay, wrap the read position, clip the wet share
    assign d_ext       = CW'(delay_reg);
    assign d_clamped   = (d_ext > HI_LIM) ? HI_LIM : ((d_ext < LO_LIM) ? LO_LIM : d_ext);
    assign pos_wrapped = (pos_reg >= SPAN) ? (pos_reg - SPAN) : pos_reg;
    assign wet_clamped = (wet_reg > spd_pkg::WET_ONE) ? spd_pkg::WET_ONE : wet_reg;
    assign dry_gain    = spd_pkg::COEF_W'(spd_pkg::WET_ONE) - spd_pkg::COEF_W'(wet_clamped);
    assign old_gain    = spd_pkg::COEF_W'(spd_pkg::FRAC_ONE) - spd_pkg::COEF_W'(f_reg);

    // Ping-pong crosses the taps held from the last enabled ping-pong request; normal mode uses the fresh ones
    assign fb_tap_l = pp_reg ? held_r_reg : tl_reg;
    assign fb_tap_r = pp_reg ? held_l_reg : tr_reg;

    // Memory ports: clearing pass or write-back on the write side, i0 then i1 on the read side
    assign ram_we      = (state_reg == spd_pkg::ST_CLEAR) || (state_reg == spd_pkg::ST_WRITE);
    assign ram_waddr   = (state_reg == spd_pkg::ST_CLEAR) ? clr_reg : wi_reg;
    assign ram_wdata_l = (state_reg == spd_pkg::ST_CLEAR) ? '0 : wl_reg;
    assign ram_wdata_r = (state_reg == spd_pkg::ST_CLEAR) ? '0 : wr_reg;
    assign ram_raddr   = (state_reg == spd_pkg::ST_RD1) ? i1_reg : i0_reg;

    assign out_load = (state_reg == spd_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    // Configuration writes
    always_comb
    begin
        enable_next = enable_reg;
        pp_next     = pp_reg;
        delay_next  = delay_reg;
        fb_next     = fb_reg;
        wet_next    = wet_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                spd_pkg::CFG_ENABLE:    enable_next = cfg_data[0];
                spd_pkg::CFG_PING_PONG: pp_next     = cfg_data[0];
                spd_pkg::CFG_DELAY:     delay_next  = cfg_data[23:0];
                spd_pkg::CFG_FEEDBACK:  fb_next     = cfg_data[14:0];
                spd_pkg::CFG_WET:       wet_next    = cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    // Issue one term to the shared multiply-add unit per step, up to STEP_MR1
    always_comb
    begin
        mac_op       = '0;
        mac_op.valid = (state_reg == spd_pkg::ST_MAC) && (step_reg <= STEP_MR1);
        case (step_reg)
            STEP_IL0:
            begin
                mac_op.first = 1'b1;
                mac_op.a     = s0_l_reg;
                mac_op.b     = old_gain;
            end
            STEP_IL1:
            begin
                mac_op.a = s1_l_reg;
                mac_op.b = spd_pkg::COEF_W'(f_reg);
            end
            STEP_IR0:
            begin
                mac_op.first = 1'b1;
                mac_op.a     = s0_r_reg;
                mac_op.b     = old_gain;
            end
            STEP_IR1:
            begin
                mac_op.a = s1_r_reg;
                mac_op.b = spd_pkg::COEF_W'(f_reg);
            end
            STEP_FBL:
            begin
                mac_op.first = 1'b1;
                mac_op.base  = spd_pkg::ACC_W'(l_reg) <<< spd_pkg::MIX_SHIFT;
                mac_op.a     = fb_tap_l;
                mac_op.b     = spd_pkg::COEF_W'(fb_reg);
            end
            STEP_ML0:
            begin
                mac_op.first = 1'b1;
                mac_op.a     = l_reg;
                mac_op.b     = dry_gain;
            end
            STEP_ML1:
            begin
                mac_op.a = tl_reg;
                mac_op.b = spd_pkg::COEF_W'(wet_clamped);
            end
            STEP_FBR:
            begin
                mac_op.first = 1'b1;
                mac_op.base  = spd_pkg::ACC_W'(r_reg) <<< spd_pkg::MIX_SHIFT;
                mac_op.a     = fb_tap_r;
                mac_op.b     = spd_pkg::COEF_W'(fb_reg);
            end
            STEP_MR0:
            begin
                mac_op.first = 1'b1;
                mac_op.a     = r_reg;
                mac_op.b     = dry_gain;
            end
            STEP_MR1:
            begin
                mac_op.a = tr_reg;
                mac_op.b = spd_pkg::COEF_W'(wet_clamped);
            end
            default:
            begin
                mac_op.valid = 1'b0;
            end
        endcase
    end

    // Sequencer: next state and datapath loads
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        clr_next       = clr_reg;
        wi_next        = wi_reg;
        held_l_next    = held_l_reg;
        held_r_next    = held_r_reg;
        out_valid_next = out_valid_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        dly_next       = dly_reg;
        pos_next       = pos_reg;
        i0_next        = i0_reg;
        i1_next        = i1_reg;
        f_next         = f_reg;
        s0_l_next      = s0_l_reg;
        s0_r_next      = s0_r_reg;
        s1_l_next      = s1_l_reg;
        s1_r_next      = s1_r_reg;
        tl_next        = tl_reg;
        tr_next        = tr_reg;
        wl_next        = wl_reg;
        wr_next        = wr_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            spd_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = spd_pkg::ST_IDLE;
                end
            end
            spd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    l_next     = left_in;
                    r_next     = right_in;
                    res_l_next = left_in;
                    res_r_next = right_in;
                    state_next = enable_reg ? spd_pkg::ST_CLAMP : spd_pkg::ST_DONE;
                end
            end
            spd_pkg::ST_CLAMP:
            begin
                dly_next   = d_clamped[DW-1:0];
                state_next = spd_pkg::ST_SPAN;
            end
            spd_pkg::ST_SPAN:
            begin
                pos_next   = PW'({wi_reg, {spd_pkg::FRAC_W{1'b0}}}) + SPAN - PW'(dly_reg);
                state_next = spd_pkg::ST_WRAP;
            end
            spd_pkg::ST_WRAP:
            begin
                i0_next    = pos_wrapped[DW-1:spd_pkg::FRAC_W];
                f_next     = pos_wrapped[spd_pkg::FRAC_W-1:0];
                state_next = spd_pkg::ST_RD0;
            end
            spd_pkg::ST_RD0:
            begin
                i1_next    = (i0_reg == LAST_IDX) ? '0 : (i0_reg + AW'(1));
                state_next = spd_pkg::ST_RD1;
            end
            spd_pkg::ST_RD1:
            begin
                s0_l_next  = ram_rdata_l;
                s0_r_next  = ram_rdata_r;
                state_next = spd_pkg::ST_RD2;
            end
            spd_pkg::ST_RD2:
            begin
                s1_l_next  = ram_rdata_l;
                s1_r_next  = ram_rdata_r;
                step_next  = STEP_IL0;
                state_next = spd_pkg::ST_MAC;
            end
            spd_pkg::ST_MAC:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == CAP_TL)
                begin
                    tl_next = spd_pkg::shift_sat(mac_acc, spd_pkg::SHIFT_FRAC);
                end
                if (step_reg == CAP_TR)
                begin
                    tr_next = spd_pkg::shift_sat(mac_acc, spd_pkg::SHIFT_FRAC);
                end
                if (step_reg == CAP_WL)
                begin
                    wl_next = spd_pkg::shift_sat(mac_acc, spd_pkg::SHIFT_GAIN);
                end
                if (step_reg == CAP_LO)
                begin
                    res_l_next = spd_pkg::shift_sat(mac_acc, spd_pkg::SHIFT_GAIN);
                end
                if (step_reg == CAP_WR)
                begin
                    wr_next = spd_pkg::shift_sat(mac_acc, spd_pkg::SHIFT_GAIN);
                end
                if (step_reg == CAP_RO)
                begin
                    res_r_next = spd_pkg::shift_sat(mac_acc, spd_pkg::SHIFT_GAIN);
                    state_next = spd_pkg::ST_WRITE;
                end
            end
            spd_pkg::ST_WRITE:
            begin
                // Memory write happens here; advance the pointer and hold taps for ping-pong
                wi_next = (wi_reg == LAST_IDX) ? '0 : (wi_reg + AW'(1));
                if (pp_reg)
                begin
                    held_l_next = tl_reg;
                    held_r_next = tr_reg;
                end
                state_next = spd_pkg::ST_DONE;
            end
            spd_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    left_out_next  = res_l_reg;
                    right_out_next = res_r_reg;
                    out_valid_next = 1'b1;
                    state_next     = spd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spd_pkg::ST_CLEAR;
            step_reg      <= '0;
            clr_reg       <= '0;
            wi_reg        <= '0;
            held_l_reg    <= '0;
            held_r_reg    <= '0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b0;
            pp_reg        <= 1'b0;
            delay_reg     <= spd_pkg::DELAY_RESET;
            fb_reg        <= '0;
            wet_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            wi_reg        <= wi_next;
            held_l_reg    <= held_l_next;
            held_r_reg    <= held_r_next;
            out_valid_reg <= out_valid_next;
            enable_reg    <= enable_next;
            pp_reg        <= pp_next;
            delay_reg     <= delay_next;
            fb_reg        <= fb_next;
            wet_reg       <= wet_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg         <= l_next;
        r_reg         <= r_next;
        dly_reg       <= dly_next;
        pos_reg       <= pos_next;
        i0_reg        <= i0_next;
        i1_reg        <= i1_next;
        f_reg         <= f_next;
        s0_l_reg      <= s0_l_next;
        s0_r_reg      <= s0_r_next;
        s1_l_reg      <= s1_l_next;
        s1_r_reg      <= s1_r_next;
        tl_reg        <= tl_next;
        tr_reg        <= tr_next;
        wl_reg        <= wl_next;
        wr_reg        <= wr_next;
        res_l_reg     <= res_l_next;
        res_r_reg     <= res_r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    // A new result appears only from the output load state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == spd_pkg::ST_DONE)
        else $error("output valid rose outside the load state");

    // The delay lines are written only by the clearing pass or the write-back
    a_ram_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == spd_pkg::ST_CLEAR || state_reg == spd_pkg::ST_WRITE))
        else $error("delay line written outside clear or write-back");

    // The write pointer moves only after a write-back
    a_wi_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (wi_reg != $past(wi_reg)) |-> $past(state_reg) == spd_pkg::ST_WRITE)
        else $error("write pointer moved without a write-back");

endmodule

// ----- rtl/spd_ram.sv -----
module spd_ram #(
    parameter int WIDTH = spd_pkg::SAMPLE_W,
    parameter int DEPTH = spd_pkg::LINE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/spd_mac.sv -----
module spd_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spd_pkg::mac_op_t                    op,
    output logic signed [spd_pkg::ACC_W-1:0]    acc
);

    logic                                   vld_reg;
    logic                                   first_reg;
    logic signed [spd_pkg::ACC_W-1:0]       prod_reg;
    logic signed [spd_pkg::ACC_W-1:0]       base_reg;
    logic signed [spd_pkg::ACC_W-1:0]       acc_reg;
    logic signed [spd_pkg::ACC_W-1:0]       prod_next;
    logic signed [spd_pkg::ACC_W-1:0]       acc_next;

    // Stage one: multiply; stage two: add to the running sum or to a fresh base
    always_comb
    begin
        prod_next = op.a * $signed({1'b0, op.b});
        acc_next  = (first_reg ? base_reg : acc_reg) + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= op.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            prod_reg  <= prod_next;
            base_reg  <= op.base;
            first_reg <= op.first;
        end
        if (vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- test/tb_top.sv -----
module tb_top;

    localparam int DEPTH       = spd_pkg::LINE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_REQS = 1400;
    localparam logic signed [spd_pkg::SAMPLE_W-1:0] SMAX = 24'sh7FFFFF;
    localparam logic signed [spd_pkg::SAMPLE_W-1:0] SMIN = 24'sh800000;

    typedef struct {
        logic signed [spd_pkg::SAMPLE_W-1:0] left;
        logic signed [spd_pkg::SAMPLE_W-1:0] right;
    } stereo_pair_t;

    // Shadow of the delay block: its own copy of both lines, the write pointer,
    // the held ping-pong taps and the register file, plus the pairs still owed.
    class delay_scoreboard;
        logic signed [spd_pkg::SAMPLE_W-1:0] left_line  [DEPTH];
        logic signed [spd_pkg::SAMPLE_W-1:0] right_line [DEPTH];
        int           wr_ptr;
        longint       held_left;
        longint       held_right;
        bit           en;
        bit           pp;
        int           delay_q;
        int           fb_gain;
        int           wet_q;
        stereo_pair_t expected_pairs[$];
        int           mismatches;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                left_line[i]  = '0;
                right_line[i] = '0;
            end
            wr_ptr     = 0;
            held_left  = 0;
            held_right = 0;
            en         = 1'b0;
            pp         = 1'b0;
            delay_q    = 256;
            fb_gain    = 0;
            wet_q      = 0;
            mismatches = 0;
        endfunction

        function longint sat24(longint v);
            if (v > SMAX)
            begin
                return SMAX;
            end
            if (v < SMIN)
            begin
                return SMIN;
            end
            return v;
        endfunction

        // Interpolate between the two entries around the fractional read point
        function longint tap_at(bit right_side, longint d);
            longint span;
            longint pos;
            longint f;
            longint s0;
            longint s1;
            int     i0;
            int     i1;
            span = longint'(DEPTH) * 256;
            pos  = (longint'(wr_ptr) * 256 + span - d) % span;
            i0   = int'(pos / 256);
            i1   = (i0 + 1) % DEPTH;
            f    = pos % 256;
            s0   = right_side ? right_line[i0] : left_line[i0];
            s1   = right_side ? right_line[i1] : left_line[i1];
            return sat24((s0 * (256 - f) + s1 * f) >>> spd_pkg::FRAC_W);
        endfunction

        function longint blend(longint dry, longint wet_tap, longint w);
            return sat24((dry * (32768 - w) + wet_tap * w) >>> spd_pkg::MIX_SHIFT);
        endfunction

        function stereo_pair_t predict_pair(logic signed [spd_pkg::SAMPLE_W-1:0] l,
                                            logic signed [spd_pkg::SAMPLE_W-1:0] r);
            stereo_pair_t res;
            longint d;
            longint w;
            longint tl;
            longint tr;
            longint lv;
            longint rv;
            lv        = longint'(l);
            rv        = longint'(r);
            res.left  = l;
            res.right = r;
            if (en)
            begin
                d = delay_q;
                if (d > longint'(DEPTH - 1) * 256)
                begin
                    d = longint'(DEPTH - 1) * 256;
                end
                if (d < 256)
                begin
                    d = 256;
                end
                w  = (wet_q > 32768) ? 32768 : wet_q;
                tl = tap_at(1'b0, d);
                tr = tap_at(1'b1, d);
                if (pp)
                begin
                    // cross-feed from the taps of the last enabled ping-pong request
                    left_line[wr_ptr]  = spd_pkg::SAMPLE_W'(
                        sat24(lv + ((held_right * fb_gain) >>> spd_pkg::MIX_SHIFT)));
                    right_line[wr_ptr] = spd_pkg::SAMPLE_W'(
                        sat24(rv + ((held_left * fb_gain) >>> spd_pkg::MIX_SHIFT)));
                    held_left  = tl;
                    held_right = tr;
                end
                else
                begin
                    left_line[wr_ptr]  = spd_pkg::SAMPLE_W'(
                        sat24(lv + ((tl * fb_gain) >>> spd_pkg::MIX_SHIFT)));
                    right_line[wr_ptr] = spd_pkg::SAMPLE_W'(
                        sat24(rv + ((tr * fb_gain) >>> spd_pkg::MIX_SHIFT)));
                end
                wr_ptr    = (wr_ptr + 1) % DEPTH;
                res.left  = spd_pkg::SAMPLE_W'(blend(lv, tl, w));
                res.right = spd_pkg::SAMPLE_W'(blend(rv, tr, w));
            end
            return res;
        endfunction

        function void note_config(logic [spd_pkg::CFG_IDX_W-1:0] idx,
                                  logic [spd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                spd_pkg::CFG_ENABLE:    en      = data[0];
                spd_pkg::CFG_PING_PONG: pp      = data[0];
                spd_pkg::CFG_DELAY:     delay_q = int'(data);
                spd_pkg::CFG_FEEDBACK:  fb_gain = int'(data[14:0]);
                spd_pkg::CFG_WET:       wet_q   = int'(data[15:0]);
                default:                ;
            endcase
        endfunction

        function void note_request(logic signed [spd_pkg::SAMPLE_W-1:0] l,
                                   logic signed [spd_pkg::SAMPLE_W-1:0] r);
            expected_pairs.push_back(predict_pair(l, r));
        endfunction

        function void check_result(logic signed [spd_pkg::SAMPLE_W-1:0] l,
                                   logic signed [spd_pkg::SAMPLE_W-1:0] r);
            stereo_pair_t want;
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 30)
                begin
                    $error("unexpected result: left_out %0d right_out %0d", l, r);
                end
                return;
            end
            want = expected_pairs.pop_front();
            if (want.left !== l)
            begin
                mismatches++;
                if (mismatches <= 30)
                begin
                    $error("left_out: expected %0d, got %0d", want.left, l);
                end
            end
            if (want.right !== r)
            begin
                mismatches++;
                if (mismatches <= 30)
                begin
                    $error("right_out: expected %0d, got %0d", want.right, r);
                end
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_stall;
    logic signed [spd_pkg::SAMPLE_W-1:0] left_in   = '0;
    logic signed [spd_pkg::SAMPLE_W-1:0] right_in  = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [spd_pkg::SAMPLE_W-1:0] left_out;
    logic signed [spd_pkg::SAMPLE_W-1:0] right_out;
    logic                                cfg_we    = 1'b0;
    logic [spd_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [spd_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

    delay_scoreboard sb;
    bit              calm = 1'b0;   // phase with no gaps and no stalls
    int              stall_hold = 0;
    int              cycle_count = 0;
    int              random_reqs = 0;

    stereo_pingpong_delay_line dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
        begin
            return $urandom_range(1, 3);
        end
        if (sel < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // Sample mix: rail values, small signals near zero, and full-range noise
    function automatic logic signed [spd_pkg::SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return SMAX;
                1:       return SMIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (sel < 40)
        begin
            return spd_pkg::SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
        end
        return spd_pkg::SAMPLE_W'($urandom);
    endfunction

    // Output side: check every accepted result, then pick the next stall level.
    // Signals are sampled as they stood at the edge; stall changes via NBA only.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(left_out, right_out);
        end
        if (stall_hold > 0)
        begin
            stall_hold--;
        end
        else if (!calm && $urandom_range(0, 99) < 30)
        begin
            out_stall  <= 1'b1;
            stall_hold = pick_gap() - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: the limit covers the clearing pass plus every request waiting
    // out the longest gap, the block's own cycles and the longest stall, several times.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stereo_pingpong_delay_line verification failed");
        $finish;
    end

    // Drop the request line for a gap of the given length
    task automatic idle_input(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Offer one stereo request and hold it until the block takes it.
    // Valid stays high into the next request when no gap follows.
    task automatic send_pair(logic signed [spd_pkg::SAMPLE_W-1:0] l,
                             logic signed [spd_pkg::SAMPLE_W-1:0] r);
        left_in  <= l;
        right_in <= r;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_request(l, r);
        if (!calm && $urandom_range(0, 99) < 35)
        begin
            idle_input(pick_gap());
        end
    endtask

    // Hold off the sender until every owed result has come, then let the
    // block settle back to idle before anything else changes.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [spd_pkg::CFG_IDX_W-1:0] idx,
                             logic [spd_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.note_config(idx, data);
    endtask

    // Write all five registers, sometimes with junk above the width of each register but the delay,
    // and optionally hit an unused index, which must change nothing.
    task automatic apply_settings(int en, int pp, int dly, int fb, int wet, bit stray);
        logic [spd_pkg::CFG_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'd0;
        write_reg(spd_pkg::CFG_ENABLE,    24'(en)  | (junk & 24'hFFFFFE));
        write_reg(spd_pkg::CFG_PING_PONG, 24'(pp)  | (junk & 24'hFFFFFE));
        write_reg(spd_pkg::CFG_DELAY,     24'(dly));
        write_reg(spd_pkg::CFG_FEEDBACK,  24'(fb)  | (junk & 24'hFF8000));
        write_reg(spd_pkg::CFG_WET,       24'(wet) | (junk & 24'hFF0000));
        if (stray)
        begin
            write_reg(spd_pkg::CFG_WET + 3'(1 + $urandom_range(0, 2)), 24'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase();
        int n;
        int dly;
        int fb;
        int wet;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            dly = $urandom_range(256, 256 * 40);   // short echo, content gets read back
        end
        else if (sel < 70)
        begin
            dly = 256 * $urandom_range(1, 40);     // whole samples, no fraction
        end
        else if (sel < 80)
        begin
            dly = $urandom_range(0, 255);          // below one sample, clamps up
        end
        else if (sel < 90)
        begin
            dly = $urandom_range(16776960, 16777215); // at or past the top, clamps down
        end
        else
        begin
            dly = int'(24'($urandom));
        end
        sel = $urandom_range(0, 99);
        fb  = (sel < 20) ? 32767 : (sel < 30) ? 0 : $urandom_range(0, 32767);
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            wet = 0;
        end
        else if (sel < 30)
        begin
            wet = 32768;
        end
        else if (sel < 40)
        begin
            wet = $urandom_range(32769, 65535);    // above one, treated as fully wet
        end
        else
        begin
            wet = $urandom_range(0, 32768);
        end
        apply_settings(($urandom_range(0, 99) < 85), $urandom_range(0, 1), dly, fb, wet,
                       ($urandom_range(0, 3) == 0));
        n = $urandom_range(60, 140);
        for (int i = 0; i < n; i++)
        begin
            send_pair(pick_sample(), pick_sample());
        end
        random_reqs += n;
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bypass at reset settings: rails and alternating bit patterns pass unchanged
        send_pair(SMAX, SMIN);
        send_pair(SMIN, SMAX);
        send_pair('0, '1);
        send_pair(24'h555555, 24'hAAAAAA);
        drain();

        // Delay below one sample, full feedback, wet above one: saturating sums
        apply_settings(1, 0, 0, 32767, 65535, 1'b0);
        send_pair(SMAX, SMIN);
        send_pair(SMAX, SMIN);
        send_pair(SMAX, SMAX);
        send_pair(SMIN, SMIN);
        send_pair(SMAX, SMIN);
        drain();

        // Ping-pong with a one-and-a-half sample delay and half wet
        apply_settings(1, 1, 384, 32767, 16384, 1'b0);
        send_pair(SMIN, SMAX);
        send_pair(SMAX, SMIN);
        send_pair('1, '0);
        send_pair(24'h400000, 24'hC00000);
        send_pair(24'h000001, '1);
        drain();

        // Delay past the top of the line, no feedback, fully wet
        apply_settings(1, 0, 16777215, 0, 32768, 1'b0);
        send_pair(pick_sample(), pick_sample());
        send_pair(pick_sample(), pick_sample());
        send_pair(pick_sample(), pick_sample());
        drain();

        // Dry only, fractional delay, with a write to an unused index
        apply_settings(1, 1, 677, 12345, 0, 1'b1);
        send_pair(pick_sample(), pick_sample());
        send_pair(SMAX, SMIN);
        send_pair(pick_sample(), pick_sample());
        drain();

        // Random phases; the first runs without any idling on either side
        calm = 1'b1;
        random_phase();
        while (random_reqs < RANDOM_REQS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            random_phase();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("stereo_pingpong_delay_line verification clean");
        end
        else
        begin
            $display("stereo_pingpong_delay_line verification failed");
        end
        $finish;
    end

endmodule
